>>> rtl/smltd_pkg.sv
`default_nettype none

package smltd_pkg;

    localparam int CNT_W   = 12;
    localparam int Q_DEPTH = 4;
    localparam int Q_AW    = 2;

    // high nibble of a type-length byte
    localparam logic [3:0] HI_STR  = 4'h0;
    localparam logic [3:0] HI_SINT = 4'h5;
    localparam logic [3:0] HI_UINT = 4'h6;
    localparam logic [3:0] HI_LIST = 4'h7;
    localparam logic [3:0] HI_EXT  = 4'h8;

    localparam logic [7:0] B_EOM    = 8'h00;
    localparam logic [7:0] B_ABSENT = 8'h01;

    typedef enum logic [2:0] {
        K_LIST     = 3'd0,
        K_UNSIGNED = 3'd1,
        K_SIGNED   = 3'd2,
        K_STRBYTE  = 3'd3,
        K_EMPTY    = 3'd4,
        K_EOM      = 3'd5,
        K_ERROR    = 3'd6
    } t_kind;

    typedef enum logic [1:0] {
        PH_TL  = 2'd0,
        PH_EXT = 2'd1,
        PH_STR = 2'd2,
        PH_VAL = 2'd3
    } t_phase;

    typedef struct packed {
        logic [7:0] rx_byte;
        logic       restart;
    } t_in_word;

    typedef struct packed {
        t_kind             token_kind;
        logic [63:0]       value;
        logic [CNT_W-1:0]  count;
        logic [CNT_W-1:0]  byte_index;
        logic              last_byte;
    } t_out_word;

    // token as it leaves the front: numeric values still raw
    typedef struct packed {
        t_out_word  tok;
        logic       sext;
        logic [3:0] vbytes;
    } t_q_word;

    typedef struct packed {
        logic not_empty;
        logic full;
    } t_q_status;

    function automatic logic [3:0] num_width(input logic [3:0] nib);
        logic [3:0] w;
        case (nib)
            4'd2:    w = 4'd1;
            4'd3:    w = 4'd2;
            4'd5:    w = 4'd4;
            4'd9:    w = 4'd8;
            default: w = 4'd0;
        endcase
        return w;
    endfunction

endpackage

`default_nettype wire

>>> rtl/smltd_front.sv
`default_nettype none

module smltd_front #(
    parameter int MAX_STRING_LEN = 4095,
    parameter int MAX_TL_BYTES   = 3
) (
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  i_take,
    input  smltd_pkg::t_in_word  i_data,
    output logic                 o_emit,
    output smltd_pkg::t_q_word   o_word
);

    localparam int EXT_W     = 4 * MAX_TL_BYTES;
    localparam int LEN_W     = (EXT_W > smltd_pkg::CNT_W) ? EXT_W : smltd_pkg::CNT_W;
    localparam int LEN_LIMIT = (MAX_STRING_LEN < 4095) ? MAX_STRING_LEN : 4095;

    typedef struct packed {
        smltd_pkg::t_phase               phase;
        logic [smltd_pkg::CNT_W-1:0]     rem;
        logic [smltd_pkg::CNT_W-1:0]     total;
        logic [63:0]                     acc;
        logic                            sext;
        logic [3:0]                      vbytes;
        logic [2:0]                      tl;
        logic [EXT_W-1:0]                ext;
    } t_fstate;

    t_fstate r_st;
    t_fstate n_st;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_st <= '0;
        end else if (i_take) begin
            r_st <= n_st;
        end
    end

    always_comb begin
        t_fstate          c_st;
        logic [3:0]       hi;
        logic [3:0]       nib;
        logic [7:0]       b;
        logic [2:0]       n;
        logic [EXT_W-1:0] new_ext;
        logic [LEN_W-1:0] len;
        logic [3:0]       w;

        b       = i_data.rx_byte;
        hi      = b[7:4];
        nib     = b[3:0];
        c_st    = i_data.restart ? t_fstate'('0) : r_st;
        n_st    = c_st;
        o_emit  = 1'b0;
        o_word  = '0;
        n       = c_st.tl + 3'd1;
        new_ext = (c_st.ext << 4) | EXT_W'(nib);
        len     = LEN_W'(new_ext) - LEN_W'(n);
        w       = smltd_pkg::num_width(nib);

        case (c_st.phase)
            smltd_pkg::PH_STR: begin
                o_emit                    = 1'b1;
                o_word.tok.token_kind     = smltd_pkg::K_STRBYTE;
                o_word.tok.value          = {56'd0, b};
                o_word.tok.count          = c_st.total;
                o_word.tok.byte_index     = c_st.total - c_st.rem;
                o_word.tok.last_byte      = (c_st.rem == 12'd1);
                n_st.rem                  = c_st.rem - 12'd1;
                if (c_st.rem == 12'd1) begin
                    n_st = '0;
                end
            end
            smltd_pkg::PH_VAL: begin
                n_st.acc = {c_st.acc[55:0], b};
                n_st.rem = c_st.rem - 12'd1;
                if (c_st.rem == 12'd1) begin
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = c_st.sext ? smltd_pkg::K_SIGNED
                                                      : smltd_pkg::K_UNSIGNED;
                    o_word.tok.value      = {c_st.acc[55:0], b};
                    o_word.sext           = c_st.sext;
                    o_word.vbytes         = c_st.vbytes;
                    n_st                  = '0;
                end
            end
            smltd_pkg::PH_EXT: begin
                if (n > 3'(MAX_TL_BYTES) ||
                    !(hi inside {smltd_pkg::HI_EXT, smltd_pkg::HI_STR})) begin
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = smltd_pkg::K_ERROR;
                    o_word.tok.value      = {56'd0, b};
                    n_st                  = '0;
                end else if (hi == smltd_pkg::HI_EXT) begin
                    n_st.ext = new_ext;
                    n_st.tl  = n;
                end else if (new_ext < EXT_W'(n)) begin
                    // nibbles give less than the type-length bytes used
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = smltd_pkg::K_ERROR;
                    o_word.tok.value      = {56'd0, b};
                    n_st                  = '0;
                end else if (len == '0) begin
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = smltd_pkg::K_EMPTY;
                    n_st                  = '0;
                end else if (LEN_W'(len) > LEN_W'(LEN_LIMIT)) begin
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = smltd_pkg::K_ERROR;
                    o_word.tok.value      = {56'd0, b};
                    n_st                  = '0;
                end else begin
                    n_st       = '0;
                    n_st.phase = smltd_pkg::PH_STR;
                    n_st.rem   = len[smltd_pkg::CNT_W-1:0];
                    n_st.total = len[smltd_pkg::CNT_W-1:0];
                end
            end
            default: begin
                if (b == smltd_pkg::B_EOM) begin
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = smltd_pkg::K_EOM;
                end else if (b == smltd_pkg::B_ABSENT) begin
                    o_emit                = 1'b1;
                    o_word.tok.token_kind = smltd_pkg::K_EMPTY;
                end else begin
                    case (hi)
                        smltd_pkg::HI_STR: begin
                            n_st.phase = smltd_pkg::PH_STR;
                            n_st.rem   = 12'(nib) - 12'd1;
                            n_st.total = 12'(nib) - 12'd1;
                        end
                        smltd_pkg::HI_EXT: begin
                            n_st       = '0;
                            n_st.phase = smltd_pkg::PH_EXT;
                            n_st.ext   = EXT_W'(nib);
                            n_st.tl    = 3'd1;
                        end
                        smltd_pkg::HI_SINT, smltd_pkg::HI_UINT: begin
                            if (w == 4'd0) begin
                                o_emit                = 1'b1;
                                o_word.tok.token_kind = smltd_pkg::K_ERROR;
                                o_word.tok.value      = {56'd0, b};
                                n_st                  = '0;
                            end else begin
                                n_st        = '0;
                                n_st.phase  = smltd_pkg::PH_VAL;
                                n_st.vbytes = w;
                                n_st.rem    = 12'(w);
                                n_st.sext   = (hi == smltd_pkg::HI_SINT);
                            end
                        end
                        smltd_pkg::HI_LIST: begin
                            o_emit                = 1'b1;
                            o_word.tok.token_kind = smltd_pkg::K_LIST;
                            o_word.tok.count      = 12'(nib);
                        end
                        default: begin
                            o_emit                = 1'b1;
                            o_word.tok.token_kind = smltd_pkg::K_ERROR;
                            o_word.tok.value      = {56'd0, b};
                            n_st                  = '0;
                        end
                    endcase
                end
            end
        endcase
    end

endmodule

`default_nettype wire

>>> rtl/smltd_fifo.sv
`default_nettype none

module smltd_fifo (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  wire                    i_wr,
    input  smltd_pkg::t_q_word     i_wr_word,
    input  wire                    i_rd,
    output smltd_pkg::t_q_word     o_rd_word,
    output smltd_pkg::t_q_status   o_status
);

    smltd_pkg::t_q_word r_mem [smltd_pkg::Q_DEPTH];

    logic [smltd_pkg::Q_AW-1:0] r_wr_ptr;
    logic [smltd_pkg::Q_AW-1:0] r_rd_ptr;
    logic [smltd_pkg::Q_AW:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (i_wr) begin
            r_mem[r_wr_ptr] <= i_wr_word;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_cnt    <= '0;
        end else begin
            if (i_wr) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (i_rd) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({i_wr, i_rd})
                2'b10:   r_cnt <= r_cnt + 1'b1;
                2'b01:   r_cnt <= r_cnt - 1'b1;
                default: r_cnt <= r_cnt;
            endcase
        end
    end

    assign o_rd_word          = r_mem[r_rd_ptr];
    assign o_status.not_empty = (r_cnt != '0);
    assign o_status.full      = (r_cnt == (smltd_pkg::Q_AW + 1)'(smltd_pkg::Q_DEPTH));

endmodule

`default_nettype wire

>>> rtl/smltd_back.sv
`default_nettype none

module smltd_back (
    input  wire                    i_clk,
    input  wire                    i_rst_n,
    input  smltd_pkg::t_q_status   i_q_status,
    input  smltd_pkg::t_q_word     i_q_word,
    output logic                   o_q_rd,
    input  wire                    i_pop,
    output logic                   o_empty,
    output smltd_pkg::t_out_word   o_data
);

    logic                  r_vld;
    smltd_pkg::t_out_word  r_word;
    smltd_pkg::t_out_word  n_word;

    // load when the output word is free or leaves this cycle
    assign o_q_rd = i_q_status.not_empty && (!r_vld || i_pop);

    always_comb begin
        logic [63:0] v;
        v      = i_q_word.tok.value;
        n_word = i_q_word.tok;
        if (i_q_word.sext) begin
            case (i_q_word.vbytes)
                4'd1:    n_word.value = {{56{v[7]}}, v[7:0]};
                4'd2:    n_word.value = {{48{v[15]}}, v[15:0]};
                4'd4:    n_word.value = {{32{v[31]}}, v[31:0]};
                default: n_word.value = v;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= 1'b0;
        end else if (o_q_rd) begin
            r_vld <= 1'b1;
        end else if (i_pop) begin
            r_vld <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_rd) begin
            r_word <= n_word;
        end
    end

    assign o_empty = !r_vld;
    assign o_data  = r_word;

endmodule

`default_nettype wire

>>> rtl/sml_tl_token_decoder_top.sv
// sml type-length token decoder
// input side is a queue: drive i_data and push; a word is taken at a clock
// edge with push high and full low. each word is one message byte plus a
// restart flag that drops any partial token before the byte is used.
// output side is a queue: while empty is low o_data holds the oldest token;
// it is taken at a clock edge with pop high and empty low.
// one byte is taken per cycle while full is low. a byte gives zero or
// one token: list headers, string bytes, completed values, empty, end of
// message, error. the decoder writes a token into the queue at the edge
// that takes its byte; the output register loads it from the queue when
// that register is free or popped (sign extension happens there).
// a four-entry queue sits between decoder and output register; while pop is
// high every cycle full stays low, otherwise the queue can fill and full
// rises, holding off input until a token leaves.
// reset (i_rst_n low at a clock edge) empties both queues and returns the
// decoder to waiting for a type-length byte; no clearing pass is needed.
`default_nettype none

module sml_tl_token_decoder_top #(
    parameter int MAX_STRING_LEN = 4095,
    parameter int MAX_TL_BYTES   = 3
) (
    input  wire                   i_clk,
    input  wire                   i_rst_n,
    input  wire                   push,
    output logic                  full,
    input  smltd_pkg::t_in_word   i_data,
    output logic                  empty,
    input  wire                   pop,
    output smltd_pkg::t_out_word  o_data
);

    logic                  take;
    logic                  emit;
    logic                  q_rd;
    smltd_pkg::t_q_word    f_word;
    smltd_pkg::t_q_word    q_word;
    smltd_pkg::t_q_status  q_status;

    assign full = q_status.full;
    assign take = push && !q_status.full;

    smltd_front #(
        .MAX_STRING_LEN (MAX_STRING_LEN),
        .MAX_TL_BYTES   (MAX_TL_BYTES)
    ) u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_take  (take),
        .i_data  (i_data),
        .o_emit  (emit),
        .o_word  (f_word)
    );

    smltd_fifo u_fifo (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr      (take && emit),
        .i_wr_word (f_word),
        .i_rd      (q_rd),
        .o_rd_word (q_word),
        .o_status  (q_status)
    );

    smltd_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_q_status (q_status),
        .i_q_word   (q_word),
        .o_q_rd     (q_rd),
        .i_pop      (pop),
        .o_empty    (empty),
        .o_data     (o_data)
    );

endmodule

`default_nettype wire
